// ----- hw/rtl/cbs_pkg.sv -----
`timescale 1ns / 1ps

package cbs_pkg;

   localparam int CELLS       = 15;
   localparam int LEVEL_W     = 16;
   localparam int CNT_W       = $clog2(CELLS + 1);
   localparam int BANK_W      = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;

   // Third balance byte: cell 12 drives two bits, cell 14 is never packed.
   localparam logic [BANK_W-1:0] B3_CELL10 = 5'h01;
   localparam logic [BANK_W-1:0] B3_CELL11 = 5'h02;
   localparam logic [BANK_W-1:0] B3_CELL12 = 5'h0C;
   localparam logic [BANK_W-1:0] B3_CELL13 = 5'h10;

   typedef enum logic {
      KIND_CELL,
      KIND_LAST
   } cbs_kind_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               request;
      cbs_kind_type       kind;
   } cbs_item_type;

   // Queue head as seen by the back part.
   typedef struct packed {
      logic         valid;
      cbs_item_type item;
   } cbs_head_type;

   typedef enum logic {
      ST_LOAD,
      ST_RANK
   } cbs_state_type;

   function automatic logic [BANK_W-1:0] pack_bank_three(input logic [CELLS-1:0] mask);
      logic [BANK_W-1:0] bits;
      bits = '0;
      if (mask[10]) bits = bits | B3_CELL10;
      if (mask[11]) bits = bits | B3_CELL11;
      if (mask[12]) bits = bits | B3_CELL12;
      if (mask[13]) bits = bits | B3_CELL13;
      return bits;
   endfunction

endpackage

// ----- hw/rtl/cbs_front.sv -----
`timescale 1ns / 1ps

module cbs_front
   import cbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // cell_level[15:0], balance_request[16]
   input  logic                  req_tlast,  // last_cell
   output cbs_head_type          head,
   input  logic                  pop
);

   cbs_item_type       slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0] fill_ff, fill_in;
   cbs_item_type       item_in;
   logic               push;

   assign req_tready = (fill_ff != QFILL_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;

   always_comb begin
      item_in.level   = req_tdata[LEVEL_W-1:0];
      item_in.request = req_tdata[LEVEL_W];
      item_in.kind    = req_tlast ? KIND_LAST : KIND_CELL;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign head.valid = (fill_ff != '0);
   assign head.item  = slots_ff[rd_ptr_ff];

   default disable iff (reset);

   a_fill_bound: assert property (@(posedge clock) fill_ff <= QFILL_W'(QUEUE_DEPTH))
      else $error("queue fill count above depth");

   a_no_pop_empty: assert property (@(posedge clock) pop |-> fill_ff != '0)
      else $error("pop from an empty queue");

   a_ptr_track: assert property (@(posedge clock)
      fill_ff == '0 || fill_ff == QFILL_W'(QUEUE_DEPTH) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with fill count");

endmodule

// ----- hw/rtl/cbs_back.sv -----
`timescale 1ns / 1ps

module cbs_back
   import cbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cbs_head_type          head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cbs_state_type         state_ff, state_in;
   logic [LEVEL_W-1:0]    level_ff [CELLS];
   logic [CELLS-1:0]      request_ff, request_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  store;
   logic                  out_free;
   logic [CELLS-2:0]      left_wins;
   logic [CELLS-1:0]      drop_left, drop_right, mask;

   // Between neighbors, the lower index wins a tie.
   always_comb begin
      for (int c = 0; c < CELLS - 1; c++) begin
         left_wins[c] = (level_ff[c] >= level_ff[c+1]);
      end
      drop_left  = '0;
      drop_right = '0;
      for (int c = 1; c < CELLS; c++) begin
         drop_left[c] = request_ff[c-1] && left_wins[c-1];
      end
      for (int c = 0; c < CELLS - 1; c++) begin
         drop_right[c] = request_ff[c+1] && !left_wins[c];
      end
      mask = request_ff & ~drop_left & ~drop_right;
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign pop      = (state_ff == ST_LOAD) && head.valid;
   assign store    = pop && (count_ff < CNT_W'(CELLS));

   always_comb begin
      state_in     = state_ff;
      request_in   = request_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_LOAD: begin
            if (store) begin
               request_in[count_ff] = head.item.request;
               count_in             = count_ff + 1'b1;
            end
            if (pop && head.item.kind == KIND_LAST) begin
               state_in = ST_RANK;
            end
         end
         ST_RANK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, pack_bank_three(mask), mask[9:5], mask[4:0], mask};
               request_in   = '0;
               count_in     = '0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         request_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         request_ff   <= request_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Levels of cells that were not loaded are never looked at: their request is clear.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (store) begin
         level_ff[count_ff] <= head.item.level;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   default disable iff (reset);

   a_count_bound: assert property (@(posedge clock) count_ff <= CNT_W'(CELLS))
      else $error("load count above cell count");

   a_set_cleared: assert property (@(posedge clock)
      state_ff == ST_RANK && out_free |=> count_ff <= CNT_W'(1) && rsp_valid_ff)
      else $error("set not cleared after ranking");

   a_mask_subset: assert property (@(posedge clock)
      state_ff == ST_RANK && out_free |=>
         (rsp_data_ff[CELLS-1:0] & ~$past(request_ff)) == '0)
      else $error("enabled cell without a balance request");

   a_no_neighbors: assert property (@(posedge clock)
      rsp_valid_ff |-> (rsp_data_ff[CELLS-1:0] & (rsp_data_ff[CELLS-1:0] >> 1)) == '0)
      else $error("two adjacent cells enabled");

endmodule

// ----- hw/rtl/cell_balance_selector.sv -----
`timescale 1ns / 1ps
// Cell balance selector.
// The request channel carries one cell per request: level in tdata[15:0], balance
// request in tdata[16], and tlast on the final cell of a set. Cells fill slots 0 to 14
// in order; cells past the fifteenth are dropped, but their tlast still ends the set.
// Slots not loaded in a set hold no request; their levels are not cleared.
// On the end of a set one response carries the enabled mask and three 5-bit balance
// bytes; a requested cell is dropped when a requested neighbor outranks it (higher
// level, lower index on a tie). Requests that do not end a set give no response.
// A four-entry queue separates the request side from the ranking logic, so requests
// keep being taken while a response waits on a stalled receiver; ranking stalls
// when the output register is still full, and the queue then fills and drops tready.
// The last cell of a set waits in the queue behind any earlier requests, is popped into the
// load registers, and the ranking state then writes the response into the output register.
// Throughput: one cell per cycle when the queue is not full; no cell is popped in the
// ranking state that ends each set, in which the single compare stage ranks the stored neighbors.
// Reset clears the queue, the stored requests, the load count and the output valid.

module cell_balance_selector
   import cbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // cell_level[15:0], balance_request[16]
   input  logic                  req_tlast,  // last_cell
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // enabled_mask[14:0], bank_one_bits[19:15], bank_two_bits[24:20], bank_three_bits[29:25]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cbs_head_type head;
   logic         pop;

   cbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .head       (head),
      .pop        (pop)
   );

   cbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
